// ----- hdl/fpd_pkg.sv -----
// Shared types and constants for the Q16.16 fixed-point divider.
package fpd_pkg;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W = 1;

    // tdata widths, padded to whole bytes
    localparam int unsigned IN_DATA_W  = 64;
    localparam int unsigned OUT_DATA_W = 32;

    localparam logic [WORD_W-1:0] ERR_VALUE = 32'h8000_0000;
    localparam logic [WORD_W-1:0] ONE_Q16   = 32'h0001_0000;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVF  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ROUNDING  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OVF_CHECK = 1'd1;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ALIGN  = 5'b00010,
        S_GUARD  = 5'b00100,
        S_STEP   = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic align;
        logic mark_ovf;
        logic guard;
        logic step;
        logic publish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic div_zero;
        logic align_more;
        logic bit_zero;
        logic div_top;
        logic step_more;
    } t_stat;

endpackage

// ----- hdl/fpd_datapath.sv -----
// Datapath of the divider: operand registers, shift/subtract unit, result register.
module fpd_datapath (
    input  logic                            i_clk,
    input  fpd_pkg::t_cmd                   i_cmd,
    input  logic [fpd_pkg::WORD_W-1:0]      i_dividend,
    input  logic [fpd_pkg::WORD_W-1:0]      i_divisor,
    input  logic                            i_round_en,
    input  logic                            i_ovf_en,
    output fpd_pkg::t_stat                  o_stat,
    output logic [fpd_pkg::WORD_W-1:0]      o_quotient,
    output logic [fpd_pkg::STATUS_W-1:0]    o_status
);

    logic [fpd_pkg::WORD_W-1:0]   r_rem, r_div, r_bit, r_quo;
    logic                         r_neg, r_ovf;
    logic [fpd_pkg::WORD_W-1:0]   r_out_quo;
    logic [fpd_pkg::STATUS_W-1:0] r_out_st;

    logic [fpd_pkg::WORD_W-1:0]   mag_a, mag_b, diff, q_round;
    logic                         ge;
    logic [fpd_pkg::WORD_W-1:0]   n_out_quo;
    logic [fpd_pkg::STATUS_W-1:0] n_out_st;

    assign mag_a = i_dividend[fpd_pkg::WORD_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign mag_b = i_divisor[fpd_pkg::WORD_W-1]  ? (~i_divisor + 1'b1)  : i_divisor;
    assign ge    = (r_rem >= r_div);
    assign diff  = r_rem - r_div;

    assign o_stat.div_zero   = (r_div == '0);
    assign o_stat.align_more = (r_div < r_rem);
    assign o_stat.bit_zero   = (r_bit == '0);
    assign o_stat.div_top    = r_div[fpd_pkg::WORD_W-1];
    assign o_stat.step_more  = (r_bit != '0) && (r_rem != '0);

    // final round-up, sign and error selection
    assign q_round = r_quo + {{(fpd_pkg::WORD_W-1){1'b0}}, (i_round_en & ge)};

    always_comb begin
        n_out_quo = fpd_pkg::ERR_VALUE;
        n_out_st  = fpd_pkg::ST_OK;
        if (r_div == '0) begin
            n_out_st = fpd_pkg::ST_ZERO;
        end else if (r_ovf) begin
            n_out_st = fpd_pkg::ST_OVF;
        end else if (r_neg && i_ovf_en && (q_round == fpd_pkg::ERR_VALUE)) begin
            n_out_st = fpd_pkg::ST_OVF;
        end else begin
            n_out_quo = r_neg ? (~q_round + 1'b1) : q_round;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= mag_a;
            r_div <= mag_b;
            r_bit <= fpd_pkg::ONE_Q16;
            r_quo <= '0;
            r_neg <= i_dividend[fpd_pkg::WORD_W-1] ^ i_divisor[fpd_pkg::WORD_W-1];
            r_ovf <= 1'b0;
        end else if (i_cmd.align) begin
            r_div <= r_div << 1;
            r_bit <= r_bit << 1;
        end else if (i_cmd.mark_ovf) begin
            r_ovf <= 1'b1;
        end else if (i_cmd.guard) begin
            if (ge) begin
                r_quo <= r_quo | r_bit;
                r_rem <= diff;
            end
            r_div <= r_div >> 1;
            r_bit <= r_bit >> 1;
        end else if (i_cmd.step) begin
            if (ge) begin
                r_quo <= r_quo | r_bit;
                r_rem <= diff << 1;
            end else begin
                r_rem <= r_rem << 1;
            end
            r_bit <= r_bit >> 1;
        end

        if (i_cmd.publish) begin
            r_out_quo <= n_out_quo;
            r_out_st  <= n_out_st;
        end
    end

    assign o_quotient = r_out_quo;
    assign o_status   = r_out_st;

endmodule

// ----- hdl/fpd_controller.sv -----
// Sequencing state machine of the divider and result-valid flag.
module fpd_controller (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  logic           i_ovf_en,
    input  fpd_pkg::t_stat i_stat,
    output fpd_pkg::t_cmd  o_cmd
);

    fpd_pkg::t_state r_state, n_state;
    logic            r_out_valid, n_out_valid;
    fpd_pkg::t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            fpd_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = fpd_pkg::S_ALIGN;
                end
            end
            fpd_pkg::S_ALIGN: begin
                if (i_stat.div_zero) begin
                    n_state = fpd_pkg::S_FINISH;
                end else if (i_stat.align_more) begin
                    cmd.align = 1'b1;
                end else if (i_ovf_en && i_stat.bit_zero) begin
                    cmd.mark_ovf = 1'b1;
                    n_state      = fpd_pkg::S_FINISH;
                end else begin
                    n_state = fpd_pkg::S_GUARD;
                end
            end
            fpd_pkg::S_GUARD: begin
                cmd.guard = i_stat.div_top;
                n_state   = fpd_pkg::S_STEP;
            end
            fpd_pkg::S_STEP: begin
                if (i_stat.step_more) begin
                    cmd.step = 1'b1;
                end else begin
                    n_state = fpd_pkg::S_FINISH;
                end
            end
            fpd_pkg::S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.publish = 1'b1;
                    n_state     = fpd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fpd_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (cmd.publish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fpd_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == fpd_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

// ----- hdl/fixed_point_divide.sv -----
// Top level of the signed Q16.16 restoring divider with its configuration registers.
//
//  Channel   Direction  Handshake                        Payload
//  -------   ---------  -------------------------------  ----------------------------------
//  s_axis    in         i_s_axis_tvalid/o_s_axis_tready  tdata: dividend [31:0], divisor [63:32]
//  m_axis    out        o_m_axis_tvalid/i_m_axis_tready  tdata: quotient [31:0]; tuser: status
//  cfg       in         i_cfg_valid/o_cfg_ready          index, 1-bit data
//
// A division runs from transfer in to result valid through the load, the alignment shifts
// and the exit from alignment, the guard, the shift/subtract steps and the exit from the loop,
// and the forming and registering of the result. Shifts and steps on the one shared
// subtract/compare unit total at most 47 (15 shifts, then 32 steps). A zero divisor goes from
// alignment straight to the finishing state. The next transfer in can be taken in the cycle
// after the result is registered. Reset (synchronous, active low) empties the block and
// sets both configuration registers to 1. A stalled result waits in the output register; the
// next item is taken meanwhile and holds in the finishing state until that result is taken.
module fixed_point_divide (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [31:0] dividend, [63:32] divisor
    input  logic [fpd_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [31:0] quotient
    output logic [fpd_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata,
    // [1:0] status
    output logic [fpd_pkg::STATUS_W-1:0]       o_m_axis_tuser,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [fpd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic                               i_cfg_data
);

    logic                           r_round_en, r_ovf_en;
    fpd_pkg::t_cmd                  cmd;
    fpd_pkg::t_stat                 stat;
    logic [fpd_pkg::WORD_W-1:0]     quotient;
    logic [fpd_pkg::STATUS_W-1:0]   status;

    // Configuration writes are always taken; only the low data bit is kept.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_round_en <= 1'b1;
            r_ovf_en   <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fpd_pkg::CFG_ROUNDING:  r_round_en <= i_cfg_data;
                fpd_pkg::CFG_OVF_CHECK: r_ovf_en   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequence the division steps and own both handshakes.
    fpd_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_ovf_en    (r_ovf_en),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Hold operands, run the shift/subtract steps and register the result.
    fpd_datapath u_dp (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_dividend (i_s_axis_tdata[fpd_pkg::WORD_W-1:0]),
        .i_divisor  (i_s_axis_tdata[2*fpd_pkg::WORD_W-1:fpd_pkg::WORD_W]),
        .i_round_en (r_round_en),
        .i_ovf_en   (r_ovf_en),
        .o_stat     (stat),
        .o_quotient (quotient),
        .o_status   (status)
    );

    // Quotient on tdata, status on tuser.
    assign o_m_axis_tdata = quotient;
    assign o_m_axis_tuser = status;

endmodule

// ----- tb/fixed_point_divide_tb.sv -----
// Self-checking testbench for the signed Q16.16 restoring divider.
module fixed_point_divide_tb;

    // One expected division result, held until the matching output transfer arrives
    typedef struct {
        logic [fpd_pkg::WORD_W-1:0]   quotient;
        logic [fpd_pkg::STATUS_W-1:0] status;
    } t_quot_rec;

    logic                               i_clk           = 1'b0;
    logic                               i_rst_n         = 1'b0;
    logic                               i_s_axis_tvalid = 1'b0;
    logic                               o_s_axis_tready;
    // [31:0] dividend, [63:32] divisor
    logic [fpd_pkg::IN_DATA_W-1:0]      i_s_axis_tdata  = '0;
    logic                               o_m_axis_tvalid;
    logic                               i_m_axis_tready = 1'b0;
    // [31:0] quotient
    logic [fpd_pkg::OUT_DATA_W-1:0]     o_m_axis_tdata;
    // [1:0] status
    logic [fpd_pkg::STATUS_W-1:0]       o_m_axis_tuser;
    logic                               i_cfg_valid     = 1'b0;
    logic                               o_cfg_ready;
    logic [fpd_pkg::CFG_IDX_W-1:0]      i_cfg_index     = '0;
    logic                               i_cfg_data      = 1'b0;

    fixed_point_divide dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // Operand pairs waiting for the driver, and quotients waiting for the DUT
    logic [fpd_pkg::IN_DATA_W-1:0] pending_ops[$];
    t_quot_rec                     quot_expected[$];

    // Shadow copies of the configuration registers, reset values first
    logic round_en   = 1'b1;
    logic ovf_chk_en = 1'b1;

    // Set when the DUT took the operand pair on the last rising edge
    logic in_accepted = 1'b0;
    // Switch off all random stalling on both sides
    logic calm        = 1'b0;

    int errors    = 0;
    int n_items   = 0;
    int n_results = 0;
    int n_zero    = 0;
    int n_ovf     = 0;
    int n_cfg     = 0;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Generous limit: the slowest legal run is a few hundred thousand time units
    initial begin
        #1000000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Predict one division: magnitudes, align, guard step, restoring steps, round, sign
    function automatic t_quot_rec divide_q16(input logic [fpd_pkg::WORD_W-1:0] num,
                                             input logic [fpd_pkg::WORD_W-1:0] den,
                                             input logic rnd, input logic chk);
        t_quot_rec                  r;
        logic [fpd_pkg::WORD_W-1:0] rem;
        logic [fpd_pkg::WORD_W-1:0] dv;
        logic [fpd_pkg::WORD_W-1:0] q;
        logic [fpd_pkg::WORD_W-1:0] qbit;
        logic                       neg;
        r.quotient = fpd_pkg::ERR_VALUE;
        r.status   = fpd_pkg::ST_OK;
        if (den == '0) begin
            r.status = fpd_pkg::ST_ZERO;
        end else begin
            rem  = num[fpd_pkg::WORD_W-1] ? (32'd0 - num) : num;
            dv   = den[fpd_pkg::WORD_W-1] ? (32'd0 - den) : den;
            q    = '0;
            qbit = fpd_pkg::ONE_Q16;
            // Shift the divisor up under the remainder; the quotient bit follows it
            while (dv < rem) begin
                dv   = dv << 1;
                qbit = qbit << 1;
            end
            if (chk && qbit == '0) begin
                r.status = fpd_pkg::ST_OVF;
            end else begin
                // Guard step: a top-bit divisor cannot be compared after a remainder shift
                if (dv[fpd_pkg::WORD_W-1]) begin
                    if (rem >= dv) begin
                        q   = q | qbit;
                        rem = rem - dv;
                    end
                    dv   = dv >> 1;
                    qbit = qbit >> 1;
                end
                while (qbit != '0 && rem != '0) begin
                    if (rem >= dv) begin
                        q   = q | qbit;
                        rem = rem - dv;
                    end
                    rem  = rem << 1;
                    qbit = qbit >> 1;
                end
                if (rnd && rem >= dv)
                    q = q + 32'd1;
                neg = num[fpd_pkg::WORD_W-1] ^ den[fpd_pkg::WORD_W-1];
                if (neg && chk && q == fpd_pkg::ERR_VALUE) begin
                    r.status = fpd_pkg::ST_OVF;
                end else begin
                    r.quotient = neg ? (32'd0 - q) : q;
                end
            end
        end
        return r;
    endfunction

    // Operand spread: full random, scaled magnitudes of either sign, powers of two, corners
    function automatic logic [fpd_pkg::WORD_W-1:0] pick_operand();
        logic [fpd_pkg::WORD_W-1:0] w;
        int                         kind;
        kind = $urandom_range(9);
        case (kind)
            0, 1, 2, 3: begin
                w = $urandom();
            end
            4, 5, 6: begin
                w = $urandom() >> $urandom_range(31);
                if ($urandom_range(1) == 1)
                    w = 32'd0 - w;
            end
            7: begin
                w = fpd_pkg::ONE_Q16 << $urandom_range(15);
                w = w >> $urandom_range(16);
                if ($urandom_range(1) == 1)
                    w = 32'd0 - w;
            end
            default: begin
                case ($urandom_range(5))
                    0: w = 32'h8000_0000;
                    1: w = 32'h7FFF_FFFF;
                    2: w = 32'hFFFF_FFFF;
                    3: w = 32'h0000_0001;
                    4: w = fpd_pkg::ONE_Q16;
                    default: w = 32'hFFFF_0000;
                endcase
            end
        endcase
        return w;
    endfunction

    // Driver: present the next operand pair once the previous one has transferred
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_m_axis_tready <= 1'b0;
        end else begin
            if (!i_s_axis_tvalid || in_accepted) begin
                if (pending_ops.size() == 0 || (!calm && $urandom_range(99) < 36)) begin
                    i_s_axis_tvalid <= 1'b0;
                end else begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= pending_ops.pop_front();
                end
            end
            i_m_axis_tready <= calm || ($urandom_range(99) >= 36);
        end
    end

    // Monitor: predict on each input transfer, check each output transfer
    always @(posedge i_clk) begin
        t_quot_rec                    want;
        logic [fpd_pkg::WORD_W-1:0]   got_q;
        logic [fpd_pkg::STATUS_W-1:0] got_s;
        in_accepted <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            quot_expected.push_back(divide_q16(
                i_s_axis_tdata[fpd_pkg::WORD_W-1:0],
                i_s_axis_tdata[2*fpd_pkg::WORD_W-1:fpd_pkg::WORD_W],
                round_en, ovf_chk_en));
            n_items++;
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_q = o_m_axis_tdata[fpd_pkg::WORD_W-1:0];
            got_s = o_m_axis_tuser;
            n_results++;
            if (got_s == fpd_pkg::ST_ZERO)
                n_zero++;
            if (got_s == fpd_pkg::ST_OVF)
                n_ovf++;
            if (quot_expected.size() == 0) begin
                $error("unexpected result: quotient %h status %0d", got_q, got_s);
                errors++;
            end else begin
                want = quot_expected.pop_front();
                if (got_q !== want.quotient) begin
                    $error("quotient mismatch: expected %h, got %h", want.quotient, got_q);
                    errors++;
                end
                if (got_s !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d", want.status, got_s);
                    errors++;
                end
            end
        end
    end

    // Hold until every queued pair has gone in and every quotient has come out
    task automatic wait_drained();
        while (pending_ops.size() != 0 || i_s_axis_tvalid || quot_expected.size() != 0)
            @(negedge i_clk);
    endtask

    // Write one configuration register and track it in the shadow copy
    task automatic write_reg(input logic [fpd_pkg::CFG_IDX_W-1:0] idx, input logic val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == fpd_pkg::CFG_ROUNDING)
            round_en = val;
        else if (idx == fpd_pkg::CFG_OVF_CHECK)
            ovf_chk_en = val;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic push_op(input logic [fpd_pkg::WORD_W-1:0] num,
                           input logic [fpd_pkg::WORD_W-1:0] den);
        pending_ops.push_back({den, num});
    endtask

    task automatic push_random(input int count);
        logic [fpd_pkg::WORD_W-1:0] num;
        logic [fpd_pkg::WORD_W-1:0] den;
        for (int k = 0; k < count; k++) begin
            num = pick_operand();
            den = pick_operand();
            // A few zero divisors on top of the corners
            if ($urandom_range(99) < 3)
                den = '0;
            push_op(num, den);
        end
    endtask

    // Corners: unit, negative minimum, alignment overflow, zero operands, rounding
    task automatic push_directed();
        push_op(32'h0001_0000, 32'h0001_0000);
        push_op(32'h8000_0000, 32'h0001_0000);
        push_op(32'h7FFF_FFFF, 32'h0000_0001);
        push_op(32'h0000_0001, 32'h7FFF_FFFF);
        push_op(32'h0000_0000, 32'h0005_0000);
        push_op(32'h1234_5678, 32'h0000_0000);
        push_op(32'h8000_0000, 32'h8000_0000);
        push_op(32'h8000_0000, 32'hFFFF_FFFF);
        push_op(32'h8000_0000, 32'hFFFF_0000);
        push_op(32'h7FFF_FFFF, 32'h8000_0000);
        push_op(32'hFFFF_FFFF, 32'h0003_0000);
        push_op(32'h0001_0000, 32'h0003_0000);
        push_op(32'h7FFF_FFFF, 32'h0000_8001);
    endtask

    // One phase: settle, configure, then feed in two halves with a full drain between
    task automatic run_phase(input logic rnd, input logic chk, input bit directed,
                             input int n_random, input logic no_stall);
        wait_drained();
        write_reg(fpd_pkg::CFG_ROUNDING, rnd);
        write_reg(fpd_pkg::CFG_OVF_CHECK, chk);
        calm = no_stall;
        if (directed)
            push_directed();
        push_random(n_random / 2);
        wait_drained();
        push_random(n_random - n_random / 2);
        wait_drained();
        calm = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corners at both register extremes, reset values first
        run_phase(1'b1, 1'b1, 1'b1, 0, 1'b0);
        run_phase(1'b0, 1'b0, 1'b1, 0, 1'b0);

        // Random traffic through every register combination, one phase without stalls
        run_phase(1'b1, 1'b1, 1'b0, 260, 1'b0);
        run_phase(1'b0, 1'b1, 1'b0, 260, 1'b1);
        run_phase(1'b1, 1'b0, 1'b0, 260, 1'b0);
        run_phase(1'b0, 1'b0, 1'b0, 260, 1'b0);
        run_phase(1'b1, 1'b1, 1'b0, 260, 1'b0);

        wait_drained();
        // Allow any stray result to surface
        repeat (100) @(negedge i_clk);
        if (quot_expected.size() != 0) begin
            $error("%0d expected results never arrived", quot_expected.size());
            errors++;
        end

        $display("Divided %0d operand pairs over %0d register writes; %0d results checked.",
                 n_items, n_cfg, n_results);
        $display("Zero-divisor results: %0d, overflow results: %0d, mismatches: %0d.",
                 n_zero, n_ovf, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/fpd_pkg.sv
hdl/fpd_datapath.sv
hdl/fpd_controller.sv
hdl/fixed_point_divide.sv
tb/fixed_point_divide_tb.sv
